### rtl/cfbde_pkg.sv
// ----------------------------------------------------------------------------
// cfbde_pkg
// Shared types and constants of the clipped framebuffer draw engine: frame
// geometry, command codes, transaction payloads and sequencer states.
// ----------------------------------------------------------------------------
package cfbde_pkg;

    localparam int WIDTH       = 17;
    localparam int HEIGHT      = 17;
    localparam int NUM_BUFFERS = 3;

    localparam int FRAME_SIZE  = WIDTH * HEIGHT;
    localparam int STORE_DEPTH = NUM_BUFFERS * FRAME_SIZE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int PIX_W   = 24;
    // Working coordinate width: holds an 8-bit origin plus a loop offset.
    localparam int COORD_W = 10;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Command codes.
    localparam logic [2:0] KIND_SET   = 3'd0;
    localparam logic [2:0] KIND_GET   = 3'd1;
    localparam logic [2:0] KIND_HLINE = 3'd2;
    localparam logic [2:0] KIND_VLINE = 3'd3;
    localparam logic [2:0] KIND_COPY  = 3'd4;

    // Register index of the line color.
    localparam logic [PADDR_W-3:0] REG_DRAW_COLOR = '0;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [PIX_W-1:0]          pix_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [1:0]        dst_buf;
        logic [1:0]        src_buf;
        logic signed [7:0] x0;
        logic signed [7:0] y0;
        logic signed [7:0] x_end;
        logic signed [7:0] y_end;
        logic signed [7:0] rect_w;
        logic signed [7:0] rect_h;
        logic signed [7:0] dst_x;
        logic signed [7:0] dst_y;
        logic [23:0]       color;
    } cmd_t;

    typedef struct packed {
        logic [23:0] pixel_color;
        logic        in_range;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_RDWAIT,
        ST_DONE
    } seq_state_t;

endpackage

### rtl/cfbde_ram.sv
// ----------------------------------------------------------------------------
// cfbde_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module cfbde_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                           wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                           rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cfbde_walker.sv
// ----------------------------------------------------------------------------
// cfbde_walker
// Command sequencer around the frame store. Every drawing command is turned
// into a clipped rectangle walk with a read stage and a write stage.
// ----------------------------------------------------------------------------
module cfbde_walker
    import cfbde_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    input  pix_t    draw_color,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    seq_state_t state_reg, state_next;
    addr_t      clr_reg;
    cmd_t       cmd_reg;

    coord_t ox_reg, oy_reg, sx_reg, sy_reg;
    coord_t i_reg, j_reg, i_hi_reg, j_lo_reg, j_hi_reg;
    logic   use_src_reg;
    pix_t   const_reg;

    logic   s2_valid_reg, s2_src_ok_reg, s2_fwd_reg;
    addr_t  s2_waddr_reg;
    pix_t   fwd_data_reg;
    result_t res_reg;

    // Memory port signals.
    logic  mem_we, mem_re;
    addr_t mem_waddr, mem_raddr;
    pix_t  mem_wdata, mem_rdata, s2_wdata;

    // Setup decode.
    coord_t ox_c, oy_c, sx_c, sy_c, is_c, ie_c, js_c, je_c;
    coord_t i_lo_c, i_hi_c, j_lo_c, j_hi_c;
    logic   use_src_c, active_c, empty_c, get_hit_c;
    pix_t   const_c;

    // Walk datapath.
    coord_t src_x, src_y, dst_x, dst_y, i_inc, j_inc;
    logic   src_ok;
    addr_t  src_addr, dst_addr, get_addr;

    function automatic logic buf_ok(input logic [1:0] b);
        return int'(b) < NUM_BUFFERS;
    endfunction

    function automatic logic in_frame(input coord_t x, input coord_t y);
        return !x[COORD_W-1] && (x < COORD_W'(WIDTH)) &&
               !y[COORD_W-1] && (y < COORD_W'(HEIGHT));
    endfunction

    function automatic addr_t pix_addr(input logic [1:0] b, input coord_t x,
                                       input coord_t y);
        return ADDR_W'(b) * ADDR_W'(FRAME_SIZE) +
               ADDR_W'($unsigned(y)) * ADDR_W'(WIDTH) + ADDR_W'($unsigned(x));
    endfunction

    // Each command kind maps onto an origin, a source origin and loop ranges.
    always_comb begin
        ox_c      = COORD_W'(cmd_reg.x0);
        oy_c      = COORD_W'(cmd_reg.y0);
        sx_c      = COORD_W'(cmd_reg.x0);
        sy_c      = COORD_W'(cmd_reg.y0);
        is_c      = '0;
        ie_c      = COORD_W'(1);
        js_c      = '0;
        je_c      = COORD_W'(1);
        use_src_c = 1'b0;
        const_c   = cmd_reg.color;
        active_c  = buf_ok(cmd_reg.dst_buf);
        unique case (cmd_reg.kind)
            KIND_SET: begin
            end
            KIND_HLINE: begin
                ox_c    = '0;
                is_c    = COORD_W'(cmd_reg.x0);
                ie_c    = COORD_W'(cmd_reg.x_end) + COORD_W'(1);
                const_c = draw_color;
            end
            KIND_VLINE: begin
                oy_c    = '0;
                js_c    = COORD_W'(cmd_reg.y0);
                je_c    = COORD_W'(cmd_reg.y_end) + COORD_W'(1);
                const_c = draw_color;
            end
            KIND_COPY: begin
                ox_c      = COORD_W'(cmd_reg.dst_x);
                oy_c      = COORD_W'(cmd_reg.dst_y);
                ie_c      = COORD_W'(cmd_reg.rect_w);
                je_c      = COORD_W'(cmd_reg.rect_h);
                use_src_c = 1'b1;
            end
            default: begin
                active_c = 1'b0;
            end
        endcase
        // Clip the loop ranges so that only destination pixels in the frame
        // are visited; skipped iterations would have written nothing.
        i_lo_c  = (is_c > -ox_c) ? is_c : -ox_c;
        i_hi_c  = (ie_c < COORD_W'(WIDTH) - ox_c) ? ie_c : COORD_W'(WIDTH) - ox_c;
        j_lo_c  = (js_c > -oy_c) ? js_c : -oy_c;
        j_hi_c  = (je_c < COORD_W'(HEIGHT) - oy_c) ? je_c : COORD_W'(HEIGHT) - oy_c;
        empty_c = !active_c || (i_lo_c >= i_hi_c) || (j_lo_c >= j_hi_c);

        get_hit_c = buf_ok(cmd_reg.dst_buf) &&
                    in_frame(COORD_W'(cmd_reg.x0), COORD_W'(cmd_reg.y0));
        get_addr  = pix_addr(cmd_reg.dst_buf, COORD_W'(cmd_reg.x0),
                             COORD_W'(cmd_reg.y0));
    end

    always_comb begin
        i_inc    = i_reg + COORD_W'(1);
        j_inc    = j_reg + COORD_W'(1);
        src_x    = sx_reg + i_reg;
        src_y    = sy_reg + j_reg;
        dst_x    = ox_reg + i_reg;
        dst_y    = oy_reg + j_reg;
        src_ok   = buf_ok(cmd_reg.src_buf) && in_frame(src_x, src_y);
        src_addr = pix_addr(cmd_reg.src_buf, src_x, src_y);
        dst_addr = pix_addr(cmd_reg.dst_buf, dst_x, dst_y);
    end

    // Write data of the pixel in the write stage; a source read issued while the
    // same pixel was being written takes the forwarded value.
    always_comb begin
        if (!use_src_reg) begin
            s2_wdata = const_reg;
        end else if (!s2_src_ok_reg) begin
            s2_wdata = '0;
        end else if (s2_fwd_reg) begin
            s2_wdata = fwd_data_reg;
        end else begin
            s2_wdata = mem_rdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = src_addr;
        mem_we     = s2_valid_reg;
        mem_waddr  = s2_waddr_reg;
        mem_wdata  = s2_wdata;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (cmd_reg.kind == KIND_GET) begin
                    mem_raddr = get_addr;
                    mem_re    = get_hit_c;
                    state_next = get_hit_c ? ST_RDWAIT : ST_DONE;
                end else begin
                    state_next = empty_c ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                mem_re = use_src_reg && src_ok;
                if ((j_inc == j_hi_reg) && (i_inc == i_hi_reg)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_RDWAIT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s2_valid_reg <= (state_reg == ST_WALK);
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_valid && cmd_ready) begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_SETUP) begin
            ox_reg      <= ox_c;
            oy_reg      <= oy_c;
            sx_reg      <= sx_c;
            sy_reg      <= sy_c;
            i_reg       <= i_lo_c;
            i_hi_reg    <= i_hi_c;
            j_reg       <= j_lo_c;
            j_lo_reg    <= j_lo_c;
            j_hi_reg    <= j_hi_c;
            use_src_reg <= use_src_c;
            const_reg   <= const_c;
            res_reg     <= '0;
        end
        if (state_reg == ST_WALK) begin
            if (j_inc == j_hi_reg) begin
                j_reg <= j_lo_reg;
                i_reg <= i_inc;
            end else begin
                j_reg <= j_inc;
            end
            s2_waddr_reg  <= dst_addr;
            s2_src_ok_reg <= src_ok;
            s2_fwd_reg    <= s2_valid_reg && (src_addr == s2_waddr_reg);
            fwd_data_reg  <= s2_wdata;
        end
        if (state_reg == ST_RDWAIT) begin
            res_reg.pixel_color <= mem_rdata;
            res_reg.in_range    <= 1'b1;
        end
    end

    assign res = res_reg;

    cfbde_ram #(
        .DATA_W(PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (int'(mem_waddr) < STORE_DEPTH))
        else $error("frame store write beyond its depth");

    a_raddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> (int'(mem_raddr) < STORE_DEPTH))
        else $error("frame store read beyond its depth");

    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !s2_valid_reg)
        else $error("result offered while a pixel write is still pending");

endmodule

### rtl/clipped_framebuffer_draw_engine_top.sv
// ----------------------------------------------------------------------------
// clipped_framebuffer_draw_engine_top
// Three 17x17 RGB framebuffers with clipped set, get, line and copy commands.
// ----------------------------------------------------------------------------
// A command is registered when accepted and decoded in a setup state. Set pixel,
// lines and copy then walk each pixel drawn inside the frame (289 at most) and
// drain the last write; a get pixel inside the frame waits for its registered
// read; a command that touches no pixel goes straight to the result. Throughput
// is one command at a time, at one pixel read-modify-write per cycle of the
// single frame store. After reset the store is swept to black with s_ready low.
// ----------------------------------------------------------------------------
module clipped_framebuffer_draw_engine_top
    import cfbde_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  cmd_t               s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output result_t            m_data
);

    pix_t    draw_color_reg;
    logic    m_valid_reg;
    result_t m_data_reg;

    logic    res_valid, res_ready;
    result_t res;
    logic    cfg_write;

    // The register file holds only the line color. Word index sits above the
    // byte offset; an access to any other word reads zero and writes nothing.
    // Configuration writes are taken at any time, also during the sweep.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[PADDR_W-1:2] == REG_DRAW_COLOR);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_DRAW_COLOR) ?
                       PDATA_W'(draw_color_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_color_reg <= '0;
        end else if (cfg_write) begin
            draw_color_reg <= pwdata[PIX_W-1:0];
        end
    end

    // The sequencer owns the frame store and works one command transaction
    // at a time; it hands its result to the output register below.
    cfbde_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (s_data),
        .draw_color(draw_color_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: it decouples the result channel, so the sequencer can
    // return to idle and take the next command while a result is waiting.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clipped framebuffer draw engine. It drives
// commands on the valid/ready input channel and collects one result per
// command on the output channel. A shadow copy of the three framebuffers,
// kept inside the bench, predicts every result. A short table of directed
// commands comes first. Random phases follow, and the line color is
// rewritten over the APB port between the phases. Both channels see random
// idle bursts, except in the final phase.
// ----------------------------------------------------------------------------
module testbench
    import cfbde_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Kinds that the engine does not implement; they must answer with zeros.
    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    localparam logic [PADDR_W-1:0] COLOR_ADDR = {REG_DRAW_COLOR, 2'b00};

    // The slowest legal run is roughly 1400 commands, each a full-frame walk at
    // worst, plus the clearing sweep after reset. The limit is several times the
    // length of that run.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 222;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic    s_valid = 1'b0;
    logic    s_ready;
    cmd_t    s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b1;
    result_t m_data;

    clipped_framebuffer_draw_engine_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Shadow state: every pixel of every buffer, and the current line color.
    pix_t shadow_fb [STORE_DEPTH];
    pix_t shadow_color;

    // Results still owed by the engine, oldest first.
    result_t pending_results [$];

    // Directed command table, walked in order before the random phases.
    cmd_t    dir_cmds    [$];
    bit      dir_typed   [$];
    result_t dir_answers [$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    bit  idle_on       = 1'b1;
    int  n_commands    = 0;
    int  n_reads       = 0;
    int  n_lines       = 0;
    int  n_copies      = 0;
    int  n_color_sets  = 0;

    // ------------------------------------------------------------------
    // Framebuffer predictor
    // ------------------------------------------------------------------

    // A pixel exists only inside the frame of a buffer that exists.
    function automatic bit fb_inside(logic [1:0] fb, int x, int y);
        return (fb < NUM_BUFFERS) && (x >= 0) && (x < WIDTH) && (y >= 0) && (y < HEIGHT);
    endfunction

    function automatic int fb_index(logic [1:0] fb, int x, int y);
        return int'(fb) * FRAME_SIZE + y * WIDTH + x;
    endfunction

    function automatic pix_t fb_read(logic [1:0] fb, int x, int y);
        if (!fb_inside(fb, x, y))
            return '0;
        return shadow_fb[fb_index(fb, x, y)];
    endfunction

    // Writes that fall outside the frame are simply dropped.
    function automatic void fb_write(logic [1:0] fb, int x, int y, pix_t px);
        if (fb_inside(fb, x, y))
            shadow_fb[fb_index(fb, x, y)] = px;
    endfunction

    // Applies one command to the shadow buffers and returns its result.
    function automatic result_t apply_draw_command(cmd_t c);
        result_t r;
        int      x0;
        int      y0;
        int      i;
        int      j;
        x0 = $signed(c.x0);
        y0 = $signed(c.y0);
        r  = '0;
        case (c.kind)
            KIND_SET: begin
                fb_write(c.dst_buf, x0, y0, c.color);
            end
            KIND_GET: begin
                if (fb_inside(c.dst_buf, x0, y0)) begin
                    r.in_range    = 1'b1;
                    r.pixel_color = fb_read(c.dst_buf, x0, y0);
                end
            end
            KIND_HLINE: begin
                // Integer loop bound, so an end of 127 does not wrap.
                for (i = x0; i <= $signed(c.x_end); i++)
                    fb_write(c.dst_buf, i, y0, shadow_color);
            end
            KIND_VLINE: begin
                for (i = y0; i <= $signed(c.y_end); i++)
                    fb_write(c.dst_buf, x0, i, shadow_color);
            end
            KIND_COPY: begin
                // Column-major walk; each write lands before the next read.
                for (i = 0; i < $signed(c.rect_w); i++)
                    for (j = 0; j < $signed(c.rect_h); j++)
                        fb_write(c.dst_buf, $signed(c.dst_x) + i, $signed(c.dst_y) + j,
                                 fb_read(c.src_buf, x0 + i, y0 + j));
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random command shaping
    // ------------------------------------------------------------------

    // Mostly coordinates around the frame, sometimes anything at all.
    function automatic logic signed [7:0] near_coord(int span);
        int v;
        if ($urandom_range(0, 9) < 8)
            v = $urandom_range(0, span + 5) - 3;
        else
            v = $urandom;
        return v[7:0];
    endfunction

    function automatic logic [1:0] pick_buffer();
        int v;
        if ($urandom_range(0, 9) == 0)
            v = $urandom_range(0, 3);
        else
            v = $urandom_range(0, NUM_BUFFERS - 1);
        return v[1:0];
    endfunction

    // Copy sizes are mostly small; a few are large or negative.
    function automatic logic signed [7:0] pick_size(int span);
        int v;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 16)
            v = $urandom_range(0, 9) - 1;
        else if (sel < 18)
            v = $urandom_range(span - 2, span + 3);
        else
            v = $urandom;
        return v[7:0];
    endfunction

    function automatic logic signed [7:0] line_end(logic signed [7:0] start, int span);
        int v;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 15)
            v = $signed(start) + $urandom_range(0, span + 2) - 2;
        else if (sel < 17)
            v = 127;
        else
            v = $urandom;
        return v[7:0];
    endfunction

    function automatic cmd_t random_draw_command();
        cmd_t        c;
        logic [95:0] noise;
        int          sel;
        // Fields that a kind does not use still carry random bits.
        noise = {$urandom, $urandom, $urandom};
        c     = noise[$bits(cmd_t)-1:0];
        sel   = $urandom_range(0, 99);
        if (sel < 28)
            c.kind = KIND_SET;
        else if (sel < 56)
            c.kind = KIND_GET;
        else if (sel < 68)
            c.kind = KIND_HLINE;
        else if (sel < 80)
            c.kind = KIND_VLINE;
        else if (sel < 96)
            c.kind = KIND_COPY;
        else
            c.kind = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
        c.dst_buf = pick_buffer();
        c.src_buf = ($urandom_range(0, 9) < 4) ? c.dst_buf : pick_buffer();
        c.x0      = near_coord(WIDTH);
        c.y0      = near_coord(HEIGHT);
        c.x_end   = line_end(c.x0, WIDTH);
        c.y_end   = line_end(c.y0, HEIGHT);
        c.rect_w  = pick_size(WIDTH);
        c.rect_h  = pick_size(HEIGHT);
        c.dst_x   = near_coord(WIDTH);
        c.dst_y   = near_coord(HEIGHT);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Directed table construction
    // ------------------------------------------------------------------

    // When typed is set, epix and ehit are the answer taken as given;
    // otherwise the row is checked against the predictor.
    task automatic add_row(logic [2:0] kind, int db, int sb, int x0, int y0, int xe, int ye,
                           int rw, int rh, int dx, int dy, int col,
                           bit typed, int epix, bit ehit);
        cmd_t    c;
        result_t r;
        c.kind        = kind;
        c.dst_buf     = db[1:0];
        c.src_buf     = sb[1:0];
        c.x0          = x0[7:0];
        c.y0          = y0[7:0];
        c.x_end       = xe[7:0];
        c.y_end       = ye[7:0];
        c.rect_w      = rw[7:0];
        c.rect_h      = rh[7:0];
        c.dst_x       = dx[7:0];
        c.dst_y       = dy[7:0];
        c.color       = col[23:0];
        r.pixel_color = epix[23:0];
        r.in_range    = ehit;
        dir_cmds.push_back(c);
        dir_typed.push_back(typed);
        dir_answers.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Bus and channel drivers
    // ------------------------------------------------------------------

    // Writes the line color over APB, then reads it back. The caller starts
    // on a clock edge with the command channel idle.
    task automatic write_draw_color(pix_t val);
        logic [PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLOR_ADDR;
        pwdata  <= PDATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        shadow_color = val;
        n_color_sets++;
        // Back-to-back read of the same register.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== PDATA_W'(val)) begin
            error_count++;
            $display("%0t: draw_color readback expected %08h actual %08h",
                     $time, PDATA_W'(val), rd);
        end
    endtask

    // Presents one command, waits for its transaction, and books the result
    // that it must cause. The caller starts on a clock edge.
    task automatic send_draw_command(cmd_t c, bit typed, result_t typed_res);
        result_t r;
        int      gap;
        if (idle_on && ($urandom_range(0, 3) == 0)) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = apply_draw_command(c);
        pending_results.push_back(typed ? typed_res : r);
        n_commands++;
        case (c.kind) inside
            KIND_GET:               n_reads++;
            KIND_HLINE, KIND_VLINE: n_lines++;
            KIND_COPY:              n_copies++;
            default: begin
            end
        endcase
    endtask

    // Result-side back-pressure: random bursts of low ready.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && ($urandom_range(0, 5) == 0)) begin
            stall_left <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result transaction is checked against the oldest booked result.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result pixel_color=%06h in_range=%0d",
                         $time, m_data.pixel_color, m_data.in_range);
            end else begin
                want = pending_results.pop_front();
                if (m_data.pixel_color !== want.pixel_color) begin
                    error_count++;
                    $display("%0t: pixel_color expected %06h actual %06h",
                             $time, want.pixel_color, m_data.pixel_color);
                end
                if (m_data.in_range !== want.in_range) begin
                    error_count++;
                    $display("%0t: in_range expected %0d actual %0d",
                             $time, want.in_range, m_data.in_range);
                end
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("clipped_framebuffer_draw_engine_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int   k;
        int   p;
        pix_t phase_color;

        for (k = 0; k < STORE_DEPTH; k++)
            shadow_fb[k] = '0;
        shadow_color = '0;

        // Directed commands. Results of drawing commands are always zero, and
        // so are reads outside the frame or from a missing buffer.
        //      kind        db sb   x0    y0   xe   ye    rw   rh   dx   dy  color
        add_row(KIND_GET,    0, 0,    0,    0,   0,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 1);
        add_row(KIND_GET,    2, 0,   16,   16,   0,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 1);
        add_row(KIND_SET,    0, 0,    0,    0,   0,   0,    0,   0,   0,   0, 24'hFFFFFF,
                1, 24'h000000, 0);
        add_row(KIND_GET,    0, 0,    0,    0,   0,   0,    0,   0,   0,   0, 0,
                1, 24'hFFFFFF, 1);
        add_row(KIND_SET,    2, 0,   16,   16,   0,   0,    0,   0,   0,   0, 24'h000001,
                1, 24'h000000, 0);
        add_row(KIND_GET,    2, 0,   16,   16,   0,   0,    0,   0,   0,   0, 0,
                1, 24'h000001, 1);
        add_row(KIND_GET,    0, 0,   17,    0,   0,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_GET,    1, 0, -128,  127,   0,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        // A buffer number past the last buffer has no pixels at all.
        add_row(KIND_SET,    3, 0,    0,    0,   0,   0,    0,   0,   0,   0, 24'h123456,
                1, 24'h000000, 0);
        add_row(KIND_GET,    3, 0,    0,    0,   0,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        // Lines over the whole coordinate range, an empty one, and ones that
        // end at 127 without wrapping.
        add_row(KIND_HLINE,  1, 0, -128,    5, 127,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_HLINE,  1, 0,    5,    6,   4,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_HLINE,  1, 0,  127,    0, 127,   0,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_VLINE,  1, 0,    3, -128,   0, 127,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_VLINE,  0, 0,   16,  127,   0, 127,    0,   0,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_GET,    1, 0,   16,    5,   0,   0,    0,   0,   0,   0, 0,
                1, 24'hA5C35A, 1);
        // Full-frame copy, an overlapping copy within one buffer, a copy from
        // a missing buffer, a copy from far outside the source, and sizes
        // that copy nothing.
        add_row(KIND_COPY,   0, 1,    0,    0,   0,   0,   17,  17,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_COPY,   1, 1,    0,    0,   0,   0,    6,   6,   1,   1, 0,
                1, 24'h000000, 0);
        add_row(KIND_GET,    1, 0,    6,    6,   0,   0,    0,   0,   0,   0, 0,
                0, 0, 0);
        add_row(KIND_COPY,   0, 3,    0,    0,   0,   0,    5,   5,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_COPY,   2, 1, -128, -128,   0,   0,  127, 127, -60, -60, 0,
                1, 24'h000000, 0);
        add_row(KIND_COPY,   1, 0,    0,    0,   0,   0, -128, 127,   0,   0, 0,
                1, 24'h000000, 0);
        add_row(KIND_RSVD5,  0, 0,    1,    1,   0,   0,    0,   0,   0,   0, 24'hFFFFFF,
                1, 24'h000000, 0);
        add_row(KIND_RSVD7,  0, 0,    1,    1,   0,   0,    0,   0,   0,   0, 24'hFFFFFF,
                1, 24'h000000, 0);

        // Synchronous reset, held low at the start and released on an edge.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // The engine clears its store after reset with s_ready low, so the
        // first command simply waits for its transaction.
        write_draw_color(24'hA5C35A);

        for (k = 0; k < dir_cmds.size(); k++)
            send_draw_command(dir_cmds[k], dir_typed[k], dir_answers[k]);

        // Random phases, each with its own line color. Color changes wait
        // until every booked result has come back.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_color = 24'hFFFFFF;
                1:       phase_color = 24'h000000;
                3:       phase_color = 24'h800001;
                default: phase_color = PIX_W'($urandom);
            endcase
            s_valid <= 1'b0;
            @(posedge aclk);
            while (pending_results.size() != 0) @(posedge aclk);
            write_draw_color(phase_color);
            // The last phase runs with both sides at full speed.
            idle_on = (p != PHASES - 1);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_draw_command(random_draw_command(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // Wait for the last results, then give stray ones time to show up.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d commands: %0d pixel reads, %0d line draws, %0d rectangle copies.",
                 n_commands, n_reads, n_lines, n_copies);
        $display("Line color written %0d times; %0d mismatches found.",
                 n_color_sets, error_count);
        if (error_count == 0) begin
            $display("clipped_framebuffer_draw_engine_top test passed");
        end else begin
            $display("clipped_framebuffer_draw_engine_top test failed");
        end
        $finish;
    end

endmodule
